// File: rtl/gpbm_pkg.sv
// Shared widths, field positions and mode codes for the glyph pixel blitter.
package gpbm_pkg;

	localparam int DIM_W          = 12;
	localparam int COORD_W        = 12;
	localparam int PIX_W          = 8;
	localparam int ACT_W          = 3;
	localparam int ADDR_W         = 22;
	localparam int PAL_ENTRIES    = 256;
	localparam int PAL_IDX_W      = 8;
	localparam int MAX_SCREEN_DIM = 2048;
	localparam int CFG_IDX_W      = 1;
	localparam int S_DATA_W       = 64;
	localparam int M_DATA_W       = 32;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
	localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

	typedef logic [ACT_W-1:0] action_t;

	localparam action_t ACT_TRANSLATE = 3'd0;
	localparam action_t ACT_REMAP     = 3'd1;
	localparam action_t ACT_BRIGHT    = 3'd2;
	localparam action_t ACT_SOLID     = 3'd3;
	localparam action_t ACT_PAL_WRITE = 3'd4;

	// colour bands that remap touches (top three bits of the source)
	localparam logic [2:0] REMAP_BAND_A = 3'b010;
	localparam logic [2:0] REMAP_BAND_B = 3'b100;

	// input request fields in s_tdata, lowest bit up
	localparam int SD_SRC_LSB    = 0;
	localparam int SD_X_LSB      = 8;
	localparam int SD_Y_LSB      = 20;
	localparam int SD_TINT_LSB   = 32;
	localparam int SD_BRIGHT_LSB = 40;
	localparam int SD_PIDX_LSB   = 48;
	localparam int SD_PVAL_LSB   = 56;

	// result fields in m_tdata
	localparam int MD_ADDR_LSB = 0;
	localparam int MD_VAL_LSB  = 22;

endpackage

// File: rtl/gpbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gpbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/glyph_pixel_blit_modes_core.sv
// Glyph pixel blitter: clip, address and colour-mode one source pixel per request.
//
// Takes one glyph pixel request per clock while the output is not stalled and returns
// exactly one result per request, sustaining one request per cycle. The y*width
// multiply with the x add and clip compares sits in the single stage between the input
// register and the result register, and the palette RAM is read once per request at
// acceptance through its one read port. The palette comes out of reset as identity
// through per-entry valid flops, so no clearing pass is needed and requests are taken
// straight after reset. A palette write only takes effect for requests accepted after
// it. The user must write screen width and height through the configuration port
// only while the block is idle, unchecked by the block; values above 2048 act as 2048.
module glyph_pixel_blit_modes_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [gpbm_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [gpbm_pkg::DIM_W-1:0]         cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// source_pixel, pixel_x, pixel_y, tint, brightness, palette_index, palette_value
	input  logic [gpbm_pkg::S_DATA_W-1:0]      s_tdata,
	// action
	input  logic [gpbm_pkg::ACT_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// write_address, write_value, two zero pad bits
	output logic [gpbm_pkg::M_DATA_W-1:0]      m_tdata,
	// write_enable
	output logic [0:0]                         m_tuser
);

	import gpbm_pkg::*;

	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_SCREEN_DIM);

	// configuration
	logic [DIM_W-1:0] scr_w_q, scr_h_q;
	logic [DIM_W-1:0] w_eff, h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= SCREEN_WIDTH_RST;
			scr_h_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_SCREEN_WIDTH:  scr_w_q <= cfg_wdata;
				CFG_SCREEN_HEIGHT: scr_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign w_eff = (scr_w_q > MAX_DIM) ? MAX_DIM : scr_w_q;
	assign h_eff = (scr_h_q > MAX_DIM) ? MAX_DIM : scr_h_q;

	// request unpacking
	action_t                in_act;
	logic [PIX_W-1:0]       in_src, in_tint, in_pidx, in_pval;
	logic [COORD_W-1:0]     in_x, in_y;
	logic [PIX_W-1:0]       in_bright;

	assign in_act    = s_tuser;
	assign in_src    = s_tdata[SD_SRC_LSB    +: PIX_W];
	assign in_x      = s_tdata[SD_X_LSB      +: COORD_W];
	assign in_y      = s_tdata[SD_Y_LSB      +: COORD_W];
	assign in_tint   = s_tdata[SD_TINT_LSB   +: PIX_W];
	assign in_bright = s_tdata[SD_BRIGHT_LSB +: PIX_W];
	assign in_pidx   = s_tdata[SD_PIDX_LSB   +: PIX_W];
	assign in_pval   = s_tdata[SD_PVAL_LSB   +: PIX_W];

	// flow control
	logic valid_s1, out_valid_q;
	logic advance, accept;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// palette: RAM plus valid flops; an unwritten entry reads as its own index
	logic [PAL_ENTRIES-1:0] pal_valid_q;
	logic                   pal_we;
	logic [PIX_W-1:0]       pal_rdata;

	assign pal_we = accept && (in_act == ACT_PAL_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
		end else if (pal_we) begin
			pal_valid_q[in_pidx] <= 1'b1;
		end
	end

	gpbm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (PAL_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (in_pidx[PAL_IDX_W-1:0]),
		.wdata (in_pval),
		.re    (accept),
		.raddr (in_src[PAL_IDX_W-1:0]),
		.rdata (pal_rdata)
	);

	// stage 1: registered request
	action_t                   act_s1;
	logic [PIX_W-1:0]          src_s1, tint_s1;
	logic [COORD_W-1:0]        x_s1, y_s1;
	logic signed [PIX_W-1:0]   bright_s1;
	logic                      pal_hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1     <= in_act;
			src_s1     <= in_src;
			x_s1       <= in_x;
			y_s1       <= in_y;
			tint_s1    <= in_tint;
			bright_s1  <= $signed(in_bright);
			pal_hit_s1 <= pal_valid_q[in_src];
		end
	end

	// clip and address
	logic                x_ok, y_ok, drawn;
	logic [ADDR_W:0]     prod, addr_sum;

	assign x_ok = !x_s1[COORD_W-1] && (|x_s1[COORD_W-2:0])
	              && ({1'b0, x_s1[COORD_W-2:0]} < w_eff);
	assign y_ok = !y_s1[COORD_W-1] && (|y_s1[COORD_W-2:0])
	              && ({1'b0, y_s1[COORD_W-2:0]} < h_eff);
	assign drawn = (act_s1 < ACT_PAL_WRITE) && (src_s1 != '0) && x_ok && y_ok;

	assign prod     = (ADDR_W+1)'(y_s1[COORD_W-2:0]) * (ADDR_W+1)'(w_eff);
	assign addr_sum = prod + (ADDR_W+1)'(x_s1[COORD_W-2:0]);

	// colour modes
	logic signed [PIX_W+1:0] b_sum, b_lo, b_hi;
	logic [PIX_W-1:0]        b_val, value;

	assign b_sum = $signed({2'b00, src_s1}) + $signed({{2{bright_s1[PIX_W-1]}}, bright_s1});
	assign b_lo  = $signed({2'b00, src_s1[7:5], 5'd0});
	assign b_hi  = $signed({2'b00, src_s1[7:5], 5'd31});

	always_comb begin
		priority if (b_sum > b_hi) begin
			b_val = b_hi[PIX_W-1:0];
		end else if (b_sum < b_lo) begin
			b_val = b_lo[PIX_W-1:0];
		end else begin
			b_val = b_sum[PIX_W-1:0];
		end
	end

	always_comb begin
		unique case (act_s1)
			ACT_TRANSLATE: value = pal_hit_s1 ? pal_rdata : src_s1;
			ACT_REMAP: begin
				if (src_s1[7:5] == REMAP_BAND_A || src_s1[7:5] == REMAP_BAND_B) begin
					value = {tint_s1[2:0], src_s1[4:0]};
				end else begin
					value = src_s1;
				end
			end
			ACT_BRIGHT:    value = b_val;
			ACT_SOLID:     value = tint_s1;
			default:       value = '0;
		endcase
	end

	// result register
	logic              out_we_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [PIX_W-1:0]  out_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_we_q   <= drawn;
			out_addr_q <= drawn ? addr_sum[ADDR_W-1:0] : '0;
			out_val_q  <= drawn ? value : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_we_q;
	assign m_tdata  = {2'b00, out_val_q, out_addr_q};

endmodule

// File: rtl/gpbm_checker.sv
// Port-level checks for the glyph pixel blitter, bound to the top level.
module gpbm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [gpbm_pkg::M_DATA_W-1:0]      m_tdata,
	input logic [0:0]                         m_tuser
);

	import gpbm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// no pixel written means zero address and value
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("non-write result carries data");

	// a drawn pixel has x > 0, so its address is never zero
	a_write_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[MD_ADDR_LSB +: ADDR_W] != '0)
		else $error("drawn pixel at address zero");

	// request taken under a stall fills the pipe; a continued stall must back-pressure
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_tvalid && s_tready && m_tvalid && !m_tready) && m_tvalid && !m_tready
		|-> !s_tready)
		else $error("request accepted with pipeline full");

endmodule

bind glyph_pixel_blit_modes_core gpbm_checker u_gpbm_checker (.*);
